// ----- design/brf_pkg.sv -----
package brf_pkg;

    localparam int DEPTH_DEF     = 1024;
    localparam int MAX_BURST_DEF = 64;

    localparam int RING_W   = 11;
    localparam int OP_W     = 3;
    localparam int CNT_W    = 7;
    localparam int STAT_W   = 2;
    localparam int STORED_W = 10;

    localparam logic [OP_W-1:0] OP_WRITE = 3'd0;
    localparam logic [OP_W-1:0] OP_READ  = 3'd1;
    localparam logic [OP_W-1:0] OP_PEEK  = 3'd2;
    localparam logic [OP_W-1:0] OP_ERASE = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;

    localparam logic [STAT_W-1:0] STS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STS_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STS_EMPTY = 2'd2;

    // one result word
    typedef struct packed {
        logic [7:0]          data;
        logic                byte_valid;
        logic                last;
        logic [STAT_W-1:0]   status;
        logic [STORED_W-1:0] stored;
        logic [CNT_W-1:0]    moved;
    } res_t;

endpackage

// ----- design/brf_ram.sv -----
module brf_ram
    import brf_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds while re is low
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/brf_ctrl.sv -----
module brf_ctrl
    import brf_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int MAX_BURST = MAX_BURST_DEF,
    parameter int PW        = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [RING_W-1:0] cfg_ring_size,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [OP_W-1:0]   op,
    input  logic [7:0]        din,
    input  logic [CNT_W-1:0]  cnt,
    input  logic              out_free,
    output logic              res_load,
    output res_t              res,
    output logic              ram_we,
    output logic [PW-1:0]     ram_waddr,
    output logic [7:0]        ram_wdata,
    output logic              ram_re,
    output logic [PW-1:0]     ram_raddr,
    input  logic [7:0]        ram_rdata
);

    localparam int SW = PW + 1;
    localparam int CW = (SW > RING_W) ? SW : RING_W;
    localparam int AW = (SW > CNT_W) ? SW : CNT_W;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

    state_t              state_reg, state_next;
    logic [SW-1:0]       s_reg, s_next;
    logic [PW-1:0]       rp_reg, rp_next;
    logic [PW-1:0]       wp_reg, wp_next;
    logic [PW-1:0]       p_reg, p_next;
    logic [CNT_W-1:0]    left_reg, left_next;
    logic [CNT_W-1:0]    moved_reg, moved_next;
    logic [STORED_W-1:0] after_reg, after_next;

    logic                accept, cfg_acc, full;
    logic [SW-1:0]       rp_x, wp_x, fill, n_s;
    logic [CNT_W-1:0]    cnt_sat, n7;
    logic [AW-1:0]       fill_a, cnt_a, n_a;
    logic [SW:0]         adv_sum;
    logic [PW-1:0]       rp_adv;
    logic [CW-1:0]       rs_w, rs_clamp;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p,
                                               input logic [SW-1:0] s);
        logic [SW-1:0] t;
        t = {1'b0, p} + SW'(1);
        return (t == s) ? '0 : t[PW-1:0];
    endfunction

    function automatic logic [STORED_W-1:0] to_stored(input logic [SW-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[STORED_W-1:0];
    endfunction

    assign rp_x = {1'b0, rp_reg};
    assign wp_x = {1'b0, wp_reg};
    // pointers always stay below the ring size
    assign fill = (wp_x >= rp_x) ? (wp_x - rp_x) : (wp_x + s_reg - rp_x);
    assign full = (fill == s_reg - SW'(1));

    assign cnt_sat = (cnt > CNT_W'(MAX_BURST)) ? CNT_W'(MAX_BURST) : cnt;
    assign fill_a  = AW'(fill);
    assign cnt_a   = AW'(cnt_sat);
    assign n_a     = (cnt_a < fill_a) ? cnt_a : fill_a;
    assign n7      = n_a[CNT_W-1:0];
    assign n_s     = n_a[SW-1:0];

    // n < s, so one conditional subtract wraps
    assign adv_sum = {1'b0, rp_x} + {1'b0, n_s};
    always_comb begin
        logic [SW:0] t;
        t = (adv_sum >= {1'b0, s_reg}) ? (adv_sum - {1'b0, s_reg}) : adv_sum;
        rp_adv = t[PW-1:0];
    end

    assign rs_w     = CW'(cfg_ring_size);
    assign rs_clamp = (rs_w < CW'(2)) ? CW'(2) :
                      ((rs_w > CW'(DEPTH)) ? CW'(DEPTH) : rs_w);

    assign cfg_ready = (state_reg == ST_IDLE);
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign in_ready  = (state_reg == ST_IDLE) && out_free && !cfg_valid;
    assign accept    = in_valid && in_ready;

    assign ram_waddr = wp_reg;
    assign ram_wdata = din;

    always_comb begin
        state_next = state_reg;
        s_next     = s_reg;
        rp_next    = rp_reg;
        wp_next    = wp_reg;
        p_next     = p_reg;
        left_next  = left_reg;
        moved_next = moved_reg;
        after_next = after_reg;
        res_load   = 1'b0;
        res        = '0;
        res.last   = 1'b1;
        res.status = STS_OK;
        res.stored = to_stored(fill);
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_raddr  = rp_reg;

        case (state_reg)
            ST_IDLE: begin
                if (cfg_acc) begin
                    s_next  = rs_clamp[SW-1:0];
                    rp_next = '0;
                    wp_next = '0;
                end else if (accept) begin
                    case (op)
                        OP_WRITE: begin
                            res_load = 1'b1;
                            if (full) begin
                                res.status = STS_FULL;
                            end else begin
                                ram_we     = 1'b1;
                                wp_next    = wrap_inc(wp_reg, s_reg);
                                res.stored = to_stored(fill + SW'(1));
                                res.moved  = CNT_W'(1);
                            end
                        end
                        OP_READ, OP_PEEK: begin
                            if (n7 == '0) begin
                                res_load   = 1'b1;
                                res.status = (fill == '0) ? STS_EMPTY : STS_OK;
                            end else begin
                                ram_re     = 1'b1;
                                p_next     = wrap_inc(rp_reg, s_reg);
                                left_next  = n7;
                                moved_next = n7;
                                state_next = ST_READ;
                                if (op == OP_READ) begin
                                    rp_next    = rp_adv;
                                    after_next = to_stored(fill - n_s);
                                end else begin
                                    after_next = to_stored(fill);
                                end
                            end
                        end
                        OP_ERASE: begin
                            res_load   = 1'b1;
                            rp_next    = rp_adv;
                            res.stored = to_stored(fill - n_s);
                            res.moved  = n7;
                        end
                        OP_CLEAR: begin
                            res_load   = 1'b1;
                            rp_next    = '0;
                            wp_next    = '0;
                            res.stored = '0;
                        end
                        default: begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                // ram_rdata holds the current byte until the word is taken
                if (out_free) begin
                    res_load       = 1'b1;
                    res.data       = ram_rdata;
                    res.byte_valid = 1'b1;
                    res.last       = (left_reg == CNT_W'(1));
                    res.stored     = after_reg;
                    res.moved      = moved_reg;
                    if (left_reg > CNT_W'(1)) begin
                        ram_re    = 1'b1;
                        ram_raddr = p_reg;
                        p_next    = wrap_inc(p_reg, s_reg);
                        left_next = left_reg - CNT_W'(1);
                    end else begin
                        left_next  = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            s_reg     <= SW'(DEPTH);
            rp_reg    <= '0;
            wp_reg    <= '0;
            left_reg  <= '0;
        end else begin
            state_reg <= state_next;
            s_reg     <= s_next;
            rp_reg    <= rp_next;
            wp_reg    <= wp_next;
            left_reg  <= left_next;
        end
    end

    always_ff @(posedge aclk) begin
        p_reg     <= p_next;
        moved_reg <= moved_next;
        after_reg <= after_next;
    end

    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_re))
        else $error("ram read and write in the same cycle");

    a_load_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        res_load |-> out_free)
        else $error("result loaded into a full output stage");

    a_burst_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |-> (left_reg != '0))
        else $error("burst running with no bytes left");

    a_cfg_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_acc |=> (rp_reg == '0) && (wp_reg == '0))
        else $error("ring size write did not empty the fifo");

    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (rp_x < s_reg) && (wp_x < s_reg))
        else $error("pointer outside the ring");

endmodule

// ----- design/byte_ring_fifo_with_peek_skip.sv -----
// A write, erase, clear or empty read gives its result word in the cycle after accept.
// A read or peek of n bytes passes each byte through the ram read register and the output
// word register, one byte per cycle while m_ready is high; the ram read port sets that rate.
// Single-result operations are accepted one per cycle while the output is free; a burst
// holds s_ready low. Reset (synchronous, aresetn low) empties the fifo and sets the ring to DEPTH.
module byte_ring_fifo_with_peek_skip
    import brf_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int MAX_BURST = MAX_BURST_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [RING_W-1:0]   cfg_ring_size,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [OP_W-1:0]     s_operation,
    input  logic [7:0]          s_data_in,
    input  logic [CNT_W-1:0]    s_count,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_data_out,
    output logic                m_byte_valid,
    output logic                m_last,
    output logic [STAT_W-1:0]   m_status,
    output logic [STORED_W-1:0] m_bytes_stored,
    output logic [CNT_W-1:0]    m_bytes_moved
);

    localparam int PW = $clog2(DEPTH);

    logic          ram_we, ram_re;
    logic [PW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_wdata, ram_rdata;
    logic          out_free, res_load;
    res_t          res;
    res_t          out_reg;
    logic          m_valid_reg, m_valid_next;

    brf_ram #(
        .DEPTH (DEPTH),
        .AW    (PW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    brf_ctrl #(
        .DEPTH     (DEPTH),
        .MAX_BURST (MAX_BURST),
        .PW        (PW)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_ring_size (cfg_ring_size),
        .in_valid      (s_valid),
        .in_ready      (s_ready),
        .op            (s_operation),
        .din           (s_data_in),
        .cnt           (s_count),
        .out_free      (out_free),
        .res_load      (res_load),
        .res           (res),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_re        (ram_re),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata)
    );

    // output word register
    assign out_free     = !m_valid_reg || m_ready;
    assign m_valid_next = res_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            out_reg <= res;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_data_out     = out_reg.data;
    assign m_byte_valid   = out_reg.byte_valid;
    assign m_last         = out_reg.last;
    assign m_status       = out_reg.status;
    assign m_bytes_stored = out_reg.stored;
    assign m_bytes_moved  = out_reg.moved;

endmodule
